>>> hdl/stpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stpt_pkg;

    // table geometry
    localparam int NEURONS = 1024;
    localparam int ADDR_W  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int CNT_W   = $clog2(NEURONS + 1);

    // unsigned fixed point, 24 fraction bits, 1.0 included
    localparam int Q_W    = 25;
    localparam int Q_FRAC = 24;
    localparam int PROD_W = 2 * Q_W;

    typedef logic [Q_W-1:0] q_t;

    localparam q_t Q_ONE = q_t'(1) << Q_FRAC;

    // register reset values
    localparam q_t UJUMP_RST   = q_t'(167772);
    localparam q_t RECOVER_RST = q_t'(8389);
    localparam q_t FACIL_RST   = q_t'(1678);

    // request codes
    localparam logic [1:0] ACT_SPIKE = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_INIT  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_UJUMP   = 2'd0;
    localparam logic [1:0] REG_RECOVER = 2'd1;
    localparam logic [1:0] REG_FACIL   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPIKE,
        ST_TICK,
        ST_FILL
    } state_t;

    typedef enum logic {
        OP_SPIKE,
        OP_TICK
    } calc_op_t;

    // clamp to 1.0
    function automatic q_t qsat(input logic [Q_W:0] v);
        qsat = (v > {1'b0, Q_ONE}) ? Q_ONE : v[Q_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/stpt_calc.sv
`timescale 1ns / 1ps
`default_nettype none

module stpt_calc (
    input  var stpt_pkg::calc_op_t op,
    input  var stpt_pkg::q_t       x_in,
    input  var stpt_pkg::q_t       u_in,
    input  var stpt_pkg::q_t       ujump,
    input  var stpt_pkg::q_t       recover_rate,
    input  var stpt_pkg::q_t       facil_rate,
    output var stpt_pkg::q_t       x_out,
    output var stpt_pkg::q_t       u_out,
    output var stpt_pkg::q_t       eff
);
    import stpt_pkg::*;

    q_t                xs;
    q_t                us;
    logic              u_below;
    q_t                d;
    q_t                a1;
    q_t                b1;
    q_t                a2;
    q_t                b2;
    logic [PROD_W-1:0] prod_a;
    logic [PROD_W-1:0] prod_b;
    q_t                pa;
    q_t                pb;

    // clamp the stored values
    assign xs = qsat({1'b0, x_in});
    assign us = qsat({1'b0, u_in});

    // distance of u from its relaxation target
    assign u_below = (ujump >= us);
    assign d       = u_below ? (ujump - us) : (us - ujump);

    // operand selection for the two shared multipliers
    always_comb
    begin
        if (op == OP_SPIKE)
        begin
            a1 = xs;
            b1 = us;
            a2 = ujump;
            b2 = Q_ONE - us;
        end
        else
        begin
            a1 = Q_ONE - xs;
            b1 = recover_rate;
            a2 = d;
            b2 = facil_rate;
        end
    end

    // truncating products, operands never above 1.0
    assign prod_a = PROD_W'(a1) * PROD_W'(b1);
    assign prod_b = PROD_W'(a2) * PROD_W'(b2);
    assign pa     = prod_a[Q_FRAC+Q_W-1:Q_FRAC];
    assign pb     = prod_b[Q_FRAC+Q_W-1:Q_FRAC];

    // new state and efficacy
    always_comb
    begin
        eff = qsat({1'b0, pa});
        if (op == OP_SPIKE)
        begin
            x_out = (pa > xs) ? '0 : (xs - pa);
            u_out = qsat({1'b0, us} + {1'b0, pb});
        end
        else
        begin
            x_out = qsat({1'b0, xs} + {1'b0, pa});
            if (u_below)
            begin
                u_out = qsat({1'b0, us} + {1'b0, pb});
            end
            else
            begin
                u_out = (pb > us) ? '0 : (us - pb);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/short_term_plasticity_table.sv
// Short-term plasticity table: a resource x and a utilisation u per
// presynaptic neuron, unsigned fixed point with 24 fraction bits, held in a
// single-port-read, single-port-write table of NEURONS entries. For a spike
// request the entry is read at the accepting edge and written back in the
// following cycle; done is then high for exactly one cycle with the efficacy
// x*u formed from the old values. The receiver cannot stall, so a result
// must be taken in the cycle it is shown. A tick request sweeps every entry
// through the same read/modify/write path and keeps busy high until the
// last entry is written back; an init request writes every entry and keeps
// busy high until the last write. After reset the block runs the same
// fill pass, with u at the reset value of ujump, before its first request;
// register writes are accepted at any time, including during that pass.

`timescale 1ns / 1ps
`default_nettype none

module short_term_plasticity_table (
    input  var logic                    clk,
    input  var logic                    rst_n,
    input  var logic                    start,
    output var logic                    busy,
    input  var logic [1:0]              action,
    input  var logic [9:0]              neuron,
    output var logic                    done,
    output var logic [9:0]              source_neuron,
    output var logic [stpt_pkg::Q_W-1:0] efficacy,
    input  var logic                    cfg_we,
    input  var logic [1:0]              cfg_index,
    input  var logic [stpt_pkg::Q_W-1:0] cfg_data
);
    import stpt_pkg::*;

    // state tables
    q_t mem_x [NEURONS];
    q_t mem_u [NEURONS];

    // configuration registers
    q_t ujump_reg;
    q_t recover_reg;
    q_t facil_reg;
    q_t cfg_sat;

    // control
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             fill_rst_reg;
    logic             fill_rst_next;
    logic             rd_vld_reg;
    logic             rd_vld_next;
    logic             done_reg;
    logic             done_next;

    // payload
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] rd_addr_next;
    logic [9:0]        src_reg;
    logic [9:0]        src_next;
    logic              in_range_reg;
    logic              in_range_next;
    q_t                rd_x_reg;
    q_t                rd_u_reg;
    logic [9:0]        source_neuron_reg;
    logic [9:0]        source_neuron_next;
    q_t                efficacy_reg;
    q_t                efficacy_next;

    // table access
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    q_t                wr_x;
    q_t                wr_u;

    // update arithmetic
    calc_op_t op;
    q_t       x_new;
    q_t       u_new;
    q_t       eff_new;

    stpt_calc u_calc (
        .op           (op),
        .x_in         (rd_x_reg),
        .u_in         (rd_u_reg),
        .ujump        (ujump_reg),
        .recover_rate (recover_reg),
        .facil_rate   (facil_reg),
        .x_out        (x_new),
        .u_out        (u_new),
        .eff          (eff_new)
    );

    // register writes, clamped to 1.0
    assign cfg_sat = qsat({1'b0, cfg_data});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ujump_reg   <= UJUMP_RST;
            recover_reg <= RECOVER_RST;
            facil_reg   <= FACIL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UJUMP:   ujump_reg   <= cfg_sat;
                REG_RECOVER: recover_reg <= cfg_sat;
                REG_FACIL:   facil_reg   <= cfg_sat;
                default:     ;
            endcase
        end
    end

    // sequencer: next state, table access and result
    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        fill_rst_next      = fill_rst_reg;
        rd_vld_next        = 1'b0;
        done_next          = 1'b0;
        rd_addr_next       = rd_addr_reg;
        src_next           = src_reg;
        in_range_next      = in_range_reg;
        source_neuron_next = source_neuron_reg;
        efficacy_next      = efficacy_reg;
        rd_en              = 1'b0;
        rd_addr            = cnt_reg[ADDR_W-1:0];
        we                 = 1'b0;
        wr_addr            = rd_addr_reg;
        wr_x               = x_new;
        wr_u               = u_new;
        op                 = OP_TICK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_SPIKE:
                        begin
                            rd_en         = 1'b1;
                            rd_addr       = ADDR_W'(neuron);
                            rd_addr_next  = ADDR_W'(neuron);
                            src_next      = neuron;
                            in_range_next = (32'(neuron) < NEURONS);
                            state_next    = ST_SPIKE;
                        end
                        ACT_TICK:
                        begin
                            cnt_next   = '0;
                            state_next = ST_TICK;
                        end
                        ACT_INIT:
                        begin
                            cnt_next      = '0;
                            fill_rst_next = 1'b0;
                            state_next    = ST_FILL;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SPIKE:
            begin
                op                 = OP_SPIKE;
                we                 = in_range_reg;
                done_next          = 1'b1;
                source_neuron_next = src_reg;
                efficacy_next      = in_range_reg ? eff_new : '0;
                state_next         = ST_IDLE;
            end

            ST_TICK:
            begin
                // read one entry ahead of the write-back
                if (cnt_reg != CNT_W'(NEURONS))
                begin
                    rd_en        = 1'b1;
                    rd_addr_next = cnt_reg[ADDR_W-1:0];
                    rd_vld_next  = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                we = rd_vld_reg;
                if (cnt_reg == CNT_W'(NEURONS) && rd_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_FILL:
            begin
                we      = 1'b1;
                wr_addr = cnt_reg[ADDR_W-1:0];
                wr_x    = Q_ONE;
                wr_u    = fill_rst_reg ? UJUMP_RST : ujump_reg;
                if (cnt_reg == CNT_W'(NEURONS - 1))
                begin
                    fill_rst_next = 1'b0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            default: ;
        endcase
    end

    // control registers; reset starts the fill pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            cnt_reg      <= '0;
            fill_rst_reg <= 1'b1;
            rd_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fill_rst_reg <= fill_rst_next;
            rd_vld_reg   <= rd_vld_next;
            done_reg     <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg       <= rd_addr_next;
        src_reg           <= src_next;
        in_range_reg      <= in_range_next;
        source_neuron_reg <= source_neuron_next;
        efficacy_reg      <= efficacy_next;
    end

    // table read with registered data, and write-back
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_u_reg <= mem_u[rd_addr];
        end
        if (we)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_u[wr_addr] <= wr_u;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign source_neuron = source_neuron_reg;
    assign efficacy      = efficacy_reg;

    // a result only follows the spike write-back cycle
    a_done_after_spike: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_SPIKE))
        else $error("result strobe without a spike write-back");

    // the read and the write-back never touch the same entry at once
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && we) |-> (rd_addr != wr_addr))
        else $error("read and write of the same entry in one cycle");

    // stored values stay within 0..1.0
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (wr_x <= Q_ONE && wr_u <= Q_ONE))
        else $error("table write above 1.0");

    // an accepted spike, tick or init makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_SPIKE || action == ACT_TICK ||
                            action == ACT_INIT)) |=> busy)
        else $error("accepted request did not make the block busy");

    // efficacy never exceeds 1.0
    a_eff_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (efficacy_reg <= Q_ONE))
        else $error("efficacy above 1.0");

endmodule

`default_nettype wire

>>> verif/stpt_efficacy_check.sv
`timescale 1ns / 1ps

module stpt_efficacy_check (
    input  var logic                     clk,
    input  var logic                     rst_n,
    input  var logic                     start,
    input  var logic                     busy,
    input  var logic [1:0]               action,
    input  var logic [9:0]               neuron,
    input  var logic                     done,
    input  var logic [9:0]               source_neuron,
    input  var logic [stpt_pkg::Q_W-1:0] efficacy,
    input  var logic                     cfg_we,
    input  var logic [1:0]               cfg_index,
    input  var logic [stpt_pkg::Q_W-1:0] cfg_data,
    output int                           mismatches,
    output int                           pending,
    output int                           checked
);
    import stpt_pkg::*;

    typedef struct packed {
        logic [9:0] neuron;
        q_t         efficacy;
    } release_t;

    // shadow copy of the table and the registers
    q_t resource_x [NEURONS];
    q_t utilisation_u [NEURONS];
    q_t ujump_q;
    q_t recover_q;
    q_t facil_q;

    // releases predicted but not yet seen, oldest first
    release_t release_due [$];

    // hold a value within 0..1.0
    function automatic q_t clamp_unit(input logic [Q_W:0] v);
        if (v[Q_W] || (v[Q_W-1:0] > Q_ONE))
            return Q_ONE;
        return v[Q_W-1:0];
    endfunction

    // fixed point product, fraction bits dropped
    function automatic q_t frac_mul(input q_t a, input q_t b);
        logic [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return p[Q_FRAC +: Q_W];
    endfunction

    // every entry back to full resource and resting utilisation
    task automatic fill_table;
        for (int i = 0; i < NEURONS; i++)
        begin
            resource_x[i]    = Q_ONE;
            utilisation_u[i] = ujump_q;
        end
    endtask

    // one time step of recovery and facilitation decay over the whole table
    task automatic relax_table;
        q_t x;
        q_t u;
        q_t d;
        for (int i = 0; i < NEURONS; i++)
        begin
            x = clamp_unit({1'b0, resource_x[i]});
            u = clamp_unit({1'b0, utilisation_u[i]});
            x = clamp_unit({1'b0, x} + {1'b0, frac_mul(Q_ONE - x, recover_q)});
            if (ujump_q >= u)
            begin
                u = clamp_unit({1'b0, u} + {1'b0, frac_mul(ujump_q - u, facil_q)});
            end
            else
            begin
                // downward step truncates toward zero, never overshoots ujump
                d = frac_mul(u - ujump_q, facil_q);
                u = (d > u) ? '0 : u - d;
            end
            resource_x[i]    = x;
            utilisation_u[i] = u;
        end
    endtask

    // efficacy from the old entry, then depress x and facilitate u
    task automatic spike_entry(input logic [9:0] n, output release_t r);
        q_t x;
        q_t u;
        q_t p;
        r.neuron   = n;
        r.efficacy = '0;
        if (n < NEURONS)
        begin
            x = clamp_unit({1'b0, resource_x[n]});
            u = clamp_unit({1'b0, utilisation_u[n]});
            p = frac_mul(x, u);
            r.efficacy       = clamp_unit({1'b0, p});
            resource_x[n]    = (p > x) ? '0 : x - p;
            utilisation_u[n] = clamp_unit({1'b0, u} + {1'b0, frac_mul(ujump_q, Q_ONE - u)});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        release_t due;
        if (!rst_n)
        begin
            ujump_q   = UJUMP_RST;
            recover_q = RECOVER_RST;
            facil_q   = FACIL_RST;
            fill_table();
            release_due.delete();
            mismatches = 0;
            checked    = 0;
        end
        else
        begin
            // a result always belongs to an earlier request, so check it first
            if (done)
            begin
                if (release_due.size() == 0)
                begin
                    $error("unexpected result: source_neuron %0d efficacy %0d",
                           source_neuron, efficacy);
                    mismatches++;
                end
                else
                begin
                    due = release_due.pop_front();
                    checked++;
                    if (source_neuron !== due.neuron)
                    begin
                        $error("source_neuron: expected %0d, actual %0d",
                               due.neuron, source_neuron);
                        mismatches++;
                    end
                    if (efficacy !== due.efficacy)
                    begin
                        $error("efficacy: expected %0d, actual %0d",
                               due.efficacy, efficacy);
                        mismatches++;
                    end
                end
            end

            // register writes, saturated at 1.0
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UJUMP:   ujump_q   = clamp_unit({1'b0, cfg_data});
                    REG_RECOVER: recover_q = clamp_unit({1'b0, cfg_data});
                    REG_FACIL:   facil_q   = clamp_unit({1'b0, cfg_data});
                    default:     ;
                endcase
            end

            // accepted request
            if (start && !busy)
            begin
                case (action)
                    ACT_SPIKE:
                    begin
                        spike_entry(neuron, due);
                        release_due.push_back(due);
                    end
                    ACT_TICK: relax_table();
                    ACT_INIT: fill_table();
                    default:  ;
                endcase
            end
        end
        pending = release_due.size();
    end

endmodule

>>> verif/tb_short_term_plasticity_table.sv
`timescale 1ns / 1ps

module tb_short_term_plasticity_table;
    import stpt_pkg::*;

    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 118;

    // codes the package leaves unnamed
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] REG_NONE   = 2'd3;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    logic [1:0]     action;
    logic [9:0]     neuron;
    logic           done;
    logic [9:0]     source_neuron;
    logic [Q_W-1:0] efficacy;
    logic           cfg_we;
    logic [1:0]     cfg_index;
    logic [Q_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int checked;
    int spikes_sent;
    int ticks_sent;
    int inits_sent;
    int ignored_sent;
    int settings_made;

    logic [9:0] hot_neuron [4];

    short_term_plasticity_table uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .neuron        (neuron),
        .done          (done),
        .source_neuron (source_neuron),
        .efficacy      (efficacy),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    stpt_efficacy_check check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .neuron        (neuron),
        .done          (done),
        .source_neuron (source_neuron),
        .efficacy      (efficacy),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // present one request and hold it until the block takes it
    task automatic request(input logic [1:0] act, input logic [9:0] nrn);
        @(negedge clk);
        start  <= 1'b1;
        action <= act;
        neuron <= nrn;
        do
            @(posedge clk);
        while (busy);
        case (act)
            ACT_SPIKE: spikes_sent++;
            ACT_TICK:  ticks_sent++;
            ACT_INIT:  inits_sent++;
            default:   ignored_sent++;
        endcase
    endtask

    // sender idle, with junk on the request fields
    task automatic pause(input int cycles);
        @(negedge clk);
        start  <= 1'b0;
        action <= 2'($urandom);
        neuron <= 10'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // wait for every release and for any table walk to finish
    task automatic settle;
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [Q_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic close_writes;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_made++;
    endtask

    // register value, weighted toward the extremes and slow rates
    function automatic q_t random_rate();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return Q_ONE;
            2:       return q_t'($urandom);
            3, 4:    return q_t'($urandom_range(0, 1 << 20));
            default: return q_t'($urandom_range(0, Q_ONE));
        endcase
    endfunction

    // mostly spikes on a few hot neurons so the state moves far from rest
    task automatic random_item(output logic [1:0] act, output logic [9:0] nrn);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            act = ACT_TICK;
        else if (pick < 8)
            act = ACT_INIT;
        else if (pick < 11)
            act = ACT_UNUSED;
        else
            act = ACT_SPIKE;
        if ($urandom_range(0, 9) < 7)
            nrn = hot_neuron[$urandom_range(0, 3)];
        else
            nrn = 10'($urandom);
    endtask

    initial
    begin
        logic [1:0] act;
        logic [9:0] nrn;
        int         burst;
        int         counted;

        start         = 1'b0;
        action        = ACT_SPIKE;
        neuron        = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_UJUMP;
        cfg_data      = '0;
        rst_n         = 1'b0;
        spikes_sent   = 0;
        ticks_sent    = 0;
        inits_sent    = 0;
        ignored_sent  = 0;
        settings_made = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // fill pass after reset
        settle();

        // reset registers: depression, recovery, unused code, field extremes
        request(ACT_INIT, 10'h000);
        request(ACT_SPIKE, 10'h000);
        request(ACT_SPIKE, 10'h3FF);
        request(ACT_SPIKE, 10'h000);
        request(ACT_TICK, 10'h000);
        request(ACT_SPIKE, 10'h000);
        request(ACT_UNUSED, 10'h3FF);
        request(ACT_SPIKE, 10'h3FF);
        request(ACT_SPIKE, 10'h155);
        request(ACT_SPIKE, 10'h2AA);
        request(ACT_SPIKE, 10'h200);
        request(ACT_TICK, 10'h155);
        request(ACT_TICK, 10'h2AA);
        request(ACT_INIT, 10'h3FF);
        request(ACT_SPIKE, 10'h000);
        settle();

        // full jump, relaxation frozen
        write_reg(REG_UJUMP, Q_ONE);
        write_reg(REG_RECOVER, '0);
        write_reg(REG_FACIL, '0);
        close_writes();
        request(ACT_SPIKE, 10'd5);
        request(ACT_SPIKE, 10'd5);
        request(ACT_TICK, 10'd0);
        request(ACT_SPIKE, 10'd5);
        settle();

        // values above 1.0 saturate, an index past the last register is ignored
        write_reg(REG_UJUMP, '1);
        write_reg(REG_RECOVER, '1);
        write_reg(REG_FACIL, '1);
        write_reg(REG_NONE, q_t'($urandom));
        close_writes();
        request(ACT_SPIKE, 10'd7);
        request(ACT_TICK, 10'd0);
        request(ACT_SPIKE, 10'd7);
        settle();

        // no jump, relaxation in one step: u driven down to zero
        write_reg(REG_UJUMP, '0);
        write_reg(REG_RECOVER, Q_ONE);
        write_reg(REG_FACIL, Q_ONE);
        close_writes();
        request(ACT_SPIKE, 10'd5);
        request(ACT_TICK, 10'd0);
        request(ACT_SPIKE, 10'd5);

        // random phases, each with fresh registers and a fresh hot set
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // hold off until every release of the last phase is in
            settle();
            write_reg(REG_UJUMP, random_rate());
            write_reg(REG_RECOVER, random_rate());
            write_reg(REG_FACIL, random_rate());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_NONE, q_t'($urandom));
            close_writes();
            for (int i = 0; i < 4; i++)
                hot_neuron[i] = 10'($urandom);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 24);
                repeat (burst)
                begin
                    random_item(act, nrn);
                    request(act, nrn);
                    if (act != ACT_UNUSED)
                        counted++;
                end
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 8));
            end
        end

        settle();
        repeat (16) @(negedge clk);

        $display("covered %0d spikes, %0d ticks, %0d inits, %0d unused-code requests",
                 spikes_sent, ticks_sent, inits_sent, ignored_sent);
        $display("over %0d register settings; %0d releases checked, %0d mismatches",
                 settings_made + 1, checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
